/* hw/rtl/stp_pkg.sv */
`timescale 1ns / 1ps
// shared constants, types and word layouts for the scope trace plotter
package stp_pkg;

    // display geometry
    localparam int COLUMNS   = 128;
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int COL_OUT_W = 7;

    // field widths
    localparam int SAMPLE_W  = 10;
    localparam int ROW_W     = 11;
    localparam int SCALE_W   = 6;
    localparam int GRID_W    = 4;
    localparam int DIV_CNT_W = $clog2(SAMPLE_W + 1);

    // stream word widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;

    // tuser bit positions on the input side
    localparam int TU_RUN  = 0;
    localparam int TU_UP   = 1;
    localparam int TU_DOWN = 2;

    // arithmetic constants
    localparam logic [SAMPLE_W-1:0] MID_CODE    = SAMPLE_W'(511);
    localparam logic [ROW_W-1:0]    ROW_BASE    = ROW_W'(31);
    localparam logic [SCALE_W-1:0]  SCALE_MAX   = SCALE_W'(32);
    localparam logic [SCALE_W-1:0]  SCALE_MIN   = SCALE_W'(1);
    localparam logic [SCALE_W-1:0]  SCALE_RESET = SCALE_W'(16);
    localparam logic [GRID_W-1:0]   GRID_LAST   = '1;

    // divider start request
    typedef struct packed {
        logic                start;
        logic [SAMPLE_W-1:0] dividend;
        logic [SCALE_W-1:0]  divisor;
    } div_req_t;

    // row store write port
    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic [ROW_W-1:0] data;
    } rs_wr_t;

    // row store read port
    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
    } rs_rd_t;

endpackage

/* hw/rtl/stp_divider.sv */
`timescale 1ns / 1ps
// bit-serial restoring divider, one quotient bit per cycle
module stp_divider
    import stp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  div_req_t            req,
    output logic                done,
    output logic [SAMPLE_W-1:0] quotient
);

    logic [SAMPLE_W-1:0]  dvd_reg;
    logic [SAMPLE_W-1:0]  dvd_next;
    logic [SCALE_W-1:0]   rem_reg;
    logic [SCALE_W-1:0]   rem_next;
    logic [SCALE_W-1:0]   div_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic [SCALE_W:0]     trial;
    logic                 fits;

    // shift the next dividend bit into the partial remainder
    always_comb begin
        trial    = {rem_reg, dvd_reg[SAMPLE_W-1]};
        fits     = trial >= {1'b0, div_reg};
        rem_next = fits ? SCALE_W'(trial - {1'b0, div_reg}) : SCALE_W'(trial);
        dvd_next = {dvd_reg[SAMPLE_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == DIV_CNT_W'(1));
            if (req.start) begin
                cnt_reg <= DIV_CNT_W'(SAMPLE_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvd_reg <= req.dividend;
            rem_reg <= '0;
            div_reg <= req.divisor;
        end else if (cnt_reg != '0) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

/* hw/rtl/stp_row_store.sv */
`timescale 1ns / 1ps
// plotted row memory, one entry per column, with per-entry valid bits
module stp_row_store
    import stp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  rs_rd_t           rd,
    input  rs_wr_t           wr,
    output logic [ROW_W-1:0] rd_row
);

    logic [ROW_W-1:0]   mem [COLUMNS];
    logic [COLUMNS-1:0] valid_reg;
    logic [ROW_W-1:0]   rd_data_reg;
    logic               rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en) begin
                rd_valid_reg <= valid_reg[rd.addr];
            end
        end
    end

    // never-written entries read as zero
    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* hw/rtl/scope_trace_plotter.sv */
`timescale 1ns / 1ps
// scope trace plotter top level: sample in, erase and draw pixel words out
//
//  channel   dir   tdata                              tuser                 tlast
//  s_        in    [9:0] adc_sample                   [0] run_enable        -
//                                                     [1] scale_up_button
//                                                     [2] scale_down_button
//  m_        out   [6:0] column, [17:7] row (signed)  [0] dot_on            last
//
// a sample with run_enable low is taken while idle and makes no output word
// a running sample holds s_tready low through the bit-serial divider (one
// quotient bit per cycle), the forming of the row, and the loading of the
// erase word, when one is needed, and then of the draw word
// s_tready is high only while no sample is in work; a stalled m_ side holds
// the output register and the sequencer waits before loading the next word
// reset is synchronous, active low; the row store reads as all zero after it
module scope_trace_plotter
    import stp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] adc_sample, rest zero
    input  logic [S_TUSER_W-1:0] s_tuser,   // [0] run_enable, [1] scale_up_button,
                                            // [2] scale_down_button
    // pixel command words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [6:0] column, [17:7] row, rest zero
    output logic                 m_tuser,   // [0] dot_on
    output logic                 m_tlast
);

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CALC  = 4'b0010,
        S_ERASE = 4'b0100,
        S_DRAW  = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;

    logic [COL_W-1:0]    col_reg;        // column for the next sample
    logic [COL_W-1:0]    work_col_reg;   // column of the sample in work
    logic [SCALE_W-1:0]  scale_reg;
    logic                up_pressed_reg;
    logic                down_pressed_reg;
    logic                neg_reg;        // sign of 511 - sample
    logic [ROW_W-1:0]    row_reg;

    // output register
    logic                m_valid_reg;
    logic [COL_W-1:0]    m_col_reg;
    logic [ROW_W-1:0]    m_row_reg;
    logic                m_dot_reg;
    logic                m_last_reg;

    logic                s_accept;
    logic                out_free;
    logic [SAMPLE_W-1:0] sample;
    logic                run;
    logic [SCALE_W-1:0]  scale_up_step;
    logic [SCALE_W-1:0]  scale_next;
    logic                sample_neg;

    div_req_t            div_req;
    logic                div_done;
    logic [SAMPLE_W-1:0] quotient;
    logic [ROW_W-1:0]    q_ext;
    logic [ROW_W-1:0]    row_calc;
    logic [ROW_W-1:0]    old_row;
    logic                erase_calc;

    rs_rd_t              rs_rd;
    rs_wr_t              rs_wr;

    assign sample   = s_tdata[SAMPLE_W-1:0];
    assign run      = s_tuser[TU_RUN];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // magnitude of 511 - sample goes to the divider, sign is kept aside
    assign sample_neg       = sample > MID_CODE;
    assign div_req.start    = s_accept && run;
    assign div_req.dividend = sample_neg ? (sample - MID_CODE) : (MID_CODE - sample);
    assign div_req.divisor  = scale_reg;

    stp_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (quotient)
    );

    // old row of this column is read while the divider runs
    assign rs_rd.en   = s_accept && run;
    assign rs_rd.addr = col_reg;

    // the new row is stored as the draw word is loaded
    assign rs_wr.en   = (state_reg == S_DRAW) && out_free;
    assign rs_wr.addr = work_col_reg;
    assign rs_wr.data = row_reg;

    stp_row_store u_rows (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (rs_rd),
        .wr      (rs_wr),
        .rd_row  (old_row)
    );

    // row = 31 + signed quotient, truncated toward zero
    always_comb begin
        q_ext    = ROW_W'(quotient);
        row_calc = ROW_BASE + (neg_reg ? (~q_ext + ROW_W'(1)) : q_ext);
        // no erase on grid lines or at row or column zero
        erase_calc = (old_row != '0) && (work_col_reg != '0)
                     && (work_col_reg[GRID_W-1:0] != GRID_LAST)
                     && (old_row[GRID_W-1:0] != GRID_LAST);
    end

    // scale buttons: up is applied first, then down, each on its rising edge
    always_comb begin
        scale_up_step = scale_reg;
        if (s_tuser[TU_UP] && !up_pressed_reg && (scale_reg < SCALE_MAX)) begin
            scale_up_step = scale_reg + SCALE_W'(1);
        end
        scale_next = scale_up_step;
        if (s_tuser[TU_DOWN] && !down_pressed_reg && (scale_up_step > SCALE_MIN)) begin
            scale_next = scale_up_step - SCALE_W'(1);
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept && run) begin
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                if (div_done) begin
                    state_next = erase_calc ? S_ERASE : S_DRAW;
                end
            end
            S_ERASE: begin
                if (out_free) begin
                    state_next = S_DRAW;
                end
            end
            S_DRAW: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            col_reg          <= '0;
            scale_reg        <= SCALE_RESET;
            up_pressed_reg   <= 1'b0;
            down_pressed_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_accept) begin
                // column advances whether or not the sample is plotted
                col_reg          <= (col_reg == COL_W'(COLUMNS - 1)) ? '0
                                    : col_reg + COL_W'(1);
                scale_reg        <= scale_next;
                up_pressed_reg   <= s_tuser[TU_UP];
                down_pressed_reg <= s_tuser[TU_DOWN];
            end
            if ((state_reg == S_ERASE || state_reg == S_DRAW) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // work and output payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            work_col_reg <= col_reg;
            neg_reg      <= sample_neg;
        end
        if (state_reg == S_CALC && div_done) begin
            row_reg <= row_calc;
        end
        if (state_reg == S_ERASE && out_free) begin
            m_col_reg  <= work_col_reg;
            m_row_reg  <= old_row;
            m_dot_reg  <= 1'b0;
            m_last_reg <= 1'b0;
        end else if (state_reg == S_DRAW && out_free) begin
            m_col_reg  <= work_col_reg;
            m_row_reg  <= row_reg;
            m_dot_reg  <= 1'b1;
            m_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_row_reg, COL_OUT_W'(m_col_reg)});
    assign m_tuser  = m_dot_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* hw/rtl/stp_checker.sv */
`timescale 1ns / 1ps
// port-level assertions for the scope trace plotter, bound to the top level
module stp_checker
    import stp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    // stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // erase words are never last, draw words always are
    a_dot_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == m_tlast))
        else $error("dot_on and last disagree");

    // a taken erase is followed at once by its draw
    a_erase_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
        else $error("draw did not follow erase");

    // a taken running sample pulls s_tready low right after it is taken
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[TU_RUN] |=> !s_tready)
        else $error("input taken during plot");

    // reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind scope_trace_plotter stp_checker u_stp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* dv/pixel_cmd_checker.sv */
`timescale 1ns / 1ps
// pixel command checker: predicts erase and draw words per sample and compares them
module pixel_cmd_checker
    import stp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser,
    input  logic                 m_tlast,
    output int                   mismatches,
    output int                   pending_words
);

    localparam logic DOT_ERASE = 1'b0;
    localparam logic DOT_DRAW  = 1'b1;

    typedef struct packed {
        logic [COL_OUT_W-1:0]        column;
        logic [ROW_W-1:0]            row;
        logic [M_TDATA_W-ROW_W-COL_OUT_W-1:0] pad;
        logic                        dot_on;
        logic                        last;
    } pixel_cmd_t;

    // trace state as the block should hold it
    logic [COL_W-1:0]   col_now;
    logic [ROW_W-1:0]   row_store [COLUMNS];
    logic [SCALE_W-1:0] scale;
    logic               up_held;
    logic               down_held;
    pixel_cmd_t         pending_pixels [$];
    int                 fail_total = 0;

    assign mismatches = fail_total;

    task automatic log_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_total++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            log_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // (v + 1) a multiple of 16 means the low four bits are all ones
    function automatic logic grid_line(input logic [3:0] low_bits);
        return low_bits == 4'hF;
    endfunction

    task automatic plot_tick(input logic [SAMPLE_W-1:0] sample, input logic run,
                             input logic up, input logic down);
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] old_row;
        pixel_cmd_t       cmd;
        int               quot;
        col = col_now;
        cmd = '0;
        cmd.column = COL_OUT_W'(col);
        if (run) begin
            old_row = row_store[col];
            if (old_row != '0 && col != '0 && !grid_line(old_row[3:0])
                    && !grid_line(4'(col))) begin
                cmd.row    = old_row;
                cmd.dot_on = DOT_ERASE;
                cmd.last   = 1'b0;
                pending_pixels.push_back(cmd);
            end
            // int division truncates toward zero, as the row formula asks
            quot = (int'(MID_CODE) - int'(sample)) / int'(scale);
            cmd.row    = ROW_W'(int'(ROW_BASE) + quot);
            cmd.dot_on = DOT_DRAW;
            cmd.last   = 1'b1;
            row_store[col] = cmd.row;
            pending_pixels.push_back(cmd);
        end
        col_now = (int'(col) == COLUMNS - 1) ? '0 : col + COL_W'(1);
        if (up && !up_held && scale < SCALE_MAX)
            scale = scale + SCALE_W'(1);
        up_held = up;
        if (down && !down_held && scale > SCALE_MIN)
            scale = scale - SCALE_W'(1);
        down_held = down;
    endtask

    always @(posedge aclk) begin
        pixel_cmd_t got;
        pixel_cmd_t want;
        if (!aresetn) begin
            col_now   = '0;
            scale     = SCALE_RESET;
            up_held   = 1'b0;
            down_held = 1'b0;
            for (int i = 0; i < COLUMNS; i++)
                row_store[i] = '0;
            pending_pixels.delete();
            pending_words <= 0;
        end else begin
            // outputs first: a word leaving now belongs to an earlier sample
            if (m_tvalid && m_tready) begin
                got = pixel_cmd_t'({m_tdata[COL_OUT_W-1:0], m_tdata[COL_OUT_W +: ROW_W],
                                    m_tdata[M_TDATA_W-1:COL_OUT_W+ROW_W], m_tuser, m_tlast});
                if (pending_pixels.size() == 0) begin
                    log_mismatch($sformatf("unexpected word column %0d row %0d",
                                           got.column, $signed(got.row)));
                end else begin
                    want = pending_pixels.pop_front();
                    check_field("column", int'(got.column), int'(want.column));
                    check_field("row", int'($signed(got.row)), int'($signed(want.row)));
                    check_field("pad bits", int'(got.pad), int'(want.pad));
                    check_field("dot_on", int'(got.dot_on), int'(want.dot_on));
                    check_field("last", int'(got.last), int'(want.last));
                end
            end
            if (s_tvalid && s_tready)
                plot_tick(s_tdata[SAMPLE_W-1:0], s_tuser[TU_RUN], s_tuser[TU_UP],
                          s_tuser[TU_DOWN]);
            pending_words <= pending_pixels.size();
        end
    end

endmodule

/* dv/tb_scope_trace_plotter.sv */
`timescale 1ns / 1ps
// testbench top for the scope trace plotter: stimulus, stall control and verdict
module tb_scope_trace_plotter;
    import stp_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_ITEMS  = 275;
    localparam int DRAIN_CYCLES = 40;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [9:0] adc_sample, rest zero
    logic [S_TUSER_W-1:0] s_tuser  = '0;   // [0] run_enable, [1] scale_up_button,
                                           // [2] scale_down_button
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [6:0] column, [17:7] row, rest zero
    logic                 m_tuser;         // [0] dot_on
    logic                 m_tlast;

    int mismatches;
    int pending_words;
    int cycle_count = 0;

    // idle percentages per phase, changed by the stimulus process
    int sender_idle_pct = 0;
    int stall_pct       = 0;

    // button levels carried from item to item so edges come from real presses
    logic up_level   = 1'b0;
    logic down_level = 1'b0;

    always #5 aclk = ~aclk;

    scope_trace_plotter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    pixel_cmd_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .mismatches    (mismatches),
        .pending_words (pending_words)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    // hard stop if words never arrive
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("scope_trace_plotter verification failed");
            $finish;
        end
    end

    // present one sample word and hold it until the block takes it
    // s_tready is read right after the edge, so it is the value the edge saw
    task automatic send_tick(input logic [SAMPLE_W-1:0] sample, input logic run,
                             input logic up, input logic down);
        logic [S_TUSER_W-1:0] flags;
        flags          = '0;
        flags[TU_RUN]  = run;
        flags[TU_UP]   = up;
        flags[TU_DOWN] = down;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(sample);
        s_tuser  <= flags;
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    // mostly uniform, with a share of codes that land on edges of the row formula
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return '1;
            2: return SAMPLE_W'(511);
            3: return SAMPLE_W'(512 + $urandom_range(0, 40));
            default: return SAMPLE_W'($urandom_range(0, 1023));
        endcase
    endfunction

    initial begin
        logic favor_up;
        int   up_toggle;
        int   down_toggle;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: sample extremes at the reset divisor of 16
        send_tick(SAMPLE_W'(0), 1'b1, 1'b0, 1'b0);      // column zero, row 62, no erase
        send_tick(SAMPLE_W'(1023), 1'b1, 1'b0, 1'b0);   // row -1
        send_tick(SAMPLE_W'(1007), 1'b1, 1'b0, 1'b0);   // row exactly zero
        send_tick(SAMPLE_W'(767), 1'b1, 1'b0, 1'b0);    // row 15, sits on a grid line
        send_tick(SAMPLE_W'(255), 1'b1, 1'b0, 1'b0);    // row 47, grid line too
        send_tick(SAMPLE_W'(511), 1'b1, 1'b0, 1'b0);    // mid code, row 31
        send_tick(SAMPLE_W'(512), 1'b1, 1'b0, 1'b0);    // -1/16 truncates to zero
        send_tick(SAMPLE_W'(528), 1'b1, 1'b0, 1'b0);    // -17/16 truncates to -1
        send_tick(SAMPLE_W'(527), 1'b1, 1'b0, 1'b0);    // -16/16 exact
        send_tick(SAMPLE_W'(682), 1'b0, 1'b0, 1'b0);    // not running, column only
        send_tick(SAMPLE_W'(341), 1'b1, 1'b1, 1'b0);    // up press
        send_tick(SAMPLE_W'(700), 1'b1, 1'b1, 1'b1);    // up held, down press
        send_tick(SAMPLE_W'(300), 1'b1, 1'b0, 1'b0);    // both released
        send_tick(SAMPLE_W'(100), 1'b1, 1'b1, 1'b1);    // both pressed on one tick
        send_tick(SAMPLE_W'(900), 1'b0, 1'b0, 1'b0);
        send_tick(SAMPLE_W'(1), 1'b1, 1'b0, 1'b0);      // column 15, a grid column

        // random phases; the button drift pushes the divisor to both limits
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  favor_up = 1'b1; end
                1: begin sender_idle_pct = 49; stall_pct = 0;  favor_up = 1'b0; end
                2: begin sender_idle_pct = 0;  stall_pct = 49; favor_up = 1'b0; end
                default: begin sender_idle_pct = 33; stall_pct = 33; favor_up = 1'b1; end
            endcase
            up_toggle   = favor_up ? 30 : 8;
            down_toggle = favor_up ? 8 : 30;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 99) < up_toggle)
                    up_level = ~up_level;
                if ($urandom_range(0, 99) < down_toggle)
                    down_level = ~down_level;
                send_tick(pick_sample(), ($urandom_range(0, 99) < 85), up_level, down_level);
            end
        end

        s_tvalid <= 1'b0;
        // one edge so the outstanding count covers the last sample taken
        @(posedge aclk);
        while (pending_words != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("scope_trace_plotter verification clean");
        else
            $display("scope_trace_plotter verification failed");
        $finish;
    end

endmodule
